FILE: sv/ptc_pkg.sv
// Shared types, constants and register indexes for the pressure and temperature compensation block.
package ptc_pkg;

   localparam int unsigned CalCount = 6;
   localparam int unsigned CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_T1_T2 = 3'd0,
      CSR_T3_P1 = 3'd1,
      CSR_P2_P3 = 3'd2,
      CSR_P4_P5 = 3'd3,
      CSR_P6_P7 = 3'd4,
      CSR_P8_P9 = 3'd5
   } csr_idx_type;

   localparam logic [31:0] K64000 = 32'd64000;
   localparam logic [31:0] K2P20  = 32'd1048576;
   localparam logic [31:0] K3125  = 32'd3125;
   localparam logic [31:0] KSign  = 32'h8000_0000;
   localparam logic [31:0] K32768 = 32'd32768;
   localparam logic [31:0] K128   = 32'd128;

   // Raw sample pair handed from the front end to the back end.
   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
   } sample_type;

   // Result of one item.
   typedef struct packed {
      logic        pressure_valid;
      logic [31:0] pressure_pa;
      logic [31:0] fine_temperature;
      logic [31:0] temperature_centi;
   } result_type;

   // Calibration words, sign-extended where signed.
   typedef struct packed {
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   } cal_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      asr = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] full;
      full = 64'(a) * 64'(b);
      mul = full[31:0];
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

endpackage

FILE: sv/pressure_temp_compensation_top.sv
// Top level of the pressure and temperature compensation block.
// Usage: calibration words are written through the csr_ channel (index 0 to 5, two 16-bit
// words per register); writes to other indexes are ignored. The user must write them
// only while idle; the block itself does not enforce it. Raw samples arrive as req_
// transfers, tdata bits 19:0 raw temperature and 39:20 raw pressure. Each sample yields
// one rsp_ transfer with the compensated temperature, fine temperature, pressure in
// pascals and a valid flag (clear when the pressure divisor is zero, pressure then zero).
// The front end holds the registers and a two-entry sample queue, so it takes new samples
// while the back end works and while a finished result waits in the output register.
// A sample goes through an idle state that takes it, five arithmetic steps, the
// bit-serial divider and a final correction step before rsp_tvalid rises. The back end
// takes a new sample only once it has finished the last one. With a zero divisor the
// divider and the correction step are skipped. When the receiver stalls the result
// holds in the output register; once the queue fills req_tready falls. Reset clears
// calibration to zero and empties the pipeline.
module pressure_temp_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // temperature_centi, fine_temperature, pressure_pa
   output logic        rsp_tuser    // pressure_valid
);
   import ptc_pkg::*;

   logic       q_valid, q_ready;
   sample_type q_sample;
   cal_type    cal;
   result_type res;

   ptc_front u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .q_valid(q_valid), .q_ready(q_ready), .q_sample(q_sample), .cal(cal)
   );

   ptc_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_sample(q_sample), .cal(cal),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_result(res)
   );

   assign rsp_tdata = {res.pressure_pa, res.fine_temperature, res.temperature_centi};
   assign rsp_tuser = res.pressure_valid;
endmodule

FILE: sv/ptc_front.sv
// Front end: calibration registers, input acceptance and a two-entry sample queue.
module ptc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,
   output logic                  q_valid,
   input  logic                  q_ready,
   output ptc_pkg::sample_type   q_sample,
   output ptc_pkg::cal_type      cal
);
   import ptc_pkg::*;

   logic [31:0] cal_ff [CalCount];
   sample_type  slot_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_sample   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CalCount; i++) cal_ff[i] <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_T1_T2: cal_ff[0] <= csr_data;
            CSR_T3_P1: cal_ff[1] <= csr_data;
            CSR_P2_P3: cal_ff[2] <= csr_data;
            CSR_P4_P5: cal_ff[3] <= csr_data;
            CSR_P6_P7: cal_ff[4] <= csr_data;
            CSR_P8_P9: cal_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= sample_type'({req_tdata[39:20], req_tdata[19:0]});
   end

   always_comb begin
      cal.t1 = {16'd0, cal_ff[0][31:16]};
      cal.t2 = sx16(cal_ff[0][15:0]);
      cal.t3 = sx16(cal_ff[1][31:16]);
      cal.p1 = {16'd0, cal_ff[1][15:0]};
      cal.p2 = sx16(cal_ff[2][31:16]);
      cal.p3 = sx16(cal_ff[2][15:0]);
      cal.p4 = sx16(cal_ff[3][31:16]);
      cal.p5 = sx16(cal_ff[3][15:0]);
      cal.p6 = sx16(cal_ff[4][31:16]);
      cal.p7 = sx16(cal_ff[4][15:0]);
      cal.p8 = sx16(cal_ff[5][31:16]);
      cal.p9 = sx16(cal_ff[5][15:0]);
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("sample queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop && !$past(reset) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow a push");
`endif
endmodule

FILE: sv/ptc_divider.sv
// Radix-2 restoring divider for 32-bit unsigned operands, one quotient bit a cycle.
module ptc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] rem_ff, quo_ff, den_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [32:0] trial;
   logic [32:0] shifted;

   assign shifted  = {rem_ff, quo_ff[31]};
   assign trial    = shifted - {1'b0, den_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= shifted[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_no_restart: assert property (@(posedge clock) disable iff (reset) busy_ff |-> !start)
      else $error("divider restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("divider done held");
   a_done_idle: assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
`endif
endmodule

FILE: sv/ptc_back.sv
// Back end: sequenced compensation arithmetic and an output register.
module ptc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  ptc_pkg::sample_type  q_sample,
   input  ptc_pkg::cal_type     cal,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output ptc_pkg::result_type  rsp_result
);
   import ptc_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_TEMP  = 8'b00000010,
      S_TEMP2 = 8'b00000100,
      S_PRE   = 8'b00001000,
      S_PRE2  = 8'b00010000,
      S_PRE3  = 8'b00100000,
      S_DIV   = 8'b01000000,
      S_POST  = 8'b10000000
   } state_type;

   state_type   state_ff, state_in;
   sample_type  smp_ff;
   logic [31:0] a_ff, d2_ff, tf_ff, tc_ff, pa_ff, q2_ff, na_ff, nb_ff, p_ff, u_ff;
   logic        hi_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   logic        div_start, div_done;
   logic [31:0] div_q, div_num;
   logic        finish;
   logic        res_valid;
   logic [31:0] res_p;
   logic [31:0] tf_c, pa_c, nb, na, dv, pn, a9, b8;

   assign q_ready    = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

   ptc_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (dv),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      tf_c = a_ff + asr(mul(asr(d2_ff, 12), cal.t3), 14);
      pa_c = asr(tf_ff, 1) - K64000;
      nb   = asr(mul(asr(q2_ff, 11), cal.p6) + (mul(pa_ff, cal.p5) << 1), 2) + (cal.p4 << 16);
      na   = asr(asr(mul(cal.p3, asr(q2_ff, 13)), 3) + asr(mul(cal.p2, pa_ff), 1), 18);
      dv   = asr(mul(K32768 + na_ff, cal.p1), 15);
      pn   = mul((K2P20 - {12'd0, smp_ff.raw_pressure}) - asr(nb_ff, 12), K3125);
      div_num = (pn < KSign) ? (pn << 1) : pn;
      a9 = asr(mul(cal.p9, u_ff), 12);
      b8 = asr(mul(p_ff >> 2, cal.p8), 13);
      res_p = p_ff + asr(a9 + b8 + cal.p7, 4);
      res_valid = 1'b1;
   end

   assign div_start = (state_ff == S_PRE3) && (dv != 32'd0);
   assign finish = (state_ff == S_PRE3 && dv == 32'd0) || (state_ff == S_POST);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (q_valid) state_in = S_TEMP;
         S_TEMP:  state_in = S_TEMP2;
         S_TEMP2: state_in = S_PRE;
         S_PRE:   state_in = S_PRE2;
         S_PRE2:  state_in = S_PRE3;
         S_PRE3:  state_in = (dv == 32'd0) ? ((out_valid_ff && !rsp_tready) ? S_PRE3 : S_IDLE)
                                         : S_DIV;
         S_DIV:   if (div_done) state_in = S_POST;
         S_POST:  if (!out_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish && state_in == S_IDLE) out_valid_ff <= 1'b1;
         else if (rsp_tready)              out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: if (q_valid) smp_ff <= q_sample;
         S_TEMP: begin
            a_ff  <= asr(mul(asr({12'd0, smp_ff.raw_temperature}, 3) - (cal.t1 << 1), cal.t2), 11);
            d2_ff <= mul(asr({12'd0, smp_ff.raw_temperature}, 4) - cal.t1,
                         asr({12'd0, smp_ff.raw_temperature}, 4) - cal.t1);
         end
         S_TEMP2: begin
            tf_ff <= tf_c;
            tc_ff <= asr(mul(tf_c, 32'd5) + K128, 8);
         end
         S_PRE: begin
            pa_ff <= pa_c;
            q2_ff <= mul(asr(pa_c, 2), asr(pa_c, 2));
         end
         S_PRE2: begin
            na_ff <= na;
            nb_ff <= nb;
         end
         S_PRE3: hi_ff <= pn[31];
         S_DIV: if (div_done) begin
            p_ff <= hi_ff ? (div_q << 1) : div_q;
            u_ff <= mul((hi_ff ? (div_q << 1) : div_q) >> 3,
                        (hi_ff ? (div_q << 1) : div_q) >> 3) >> 13;
         end
         default: ;
      endcase
      if (finish && state_in == S_IDLE) begin
         out_ff.temperature_centi <= tc_ff;
         out_ff.fine_temperature  <= tf_ff;
         out_ff.pressure_pa       <= (state_ff == S_POST) ? res_p : 32'd0;
         out_ff.pressure_valid    <= (state_ff == S_POST) && res_valid;
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      q_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff) else $error("result dropped");
   a_div_only_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> dv != 32'd0) else $error("divide by zero started");
`endif
endmodule

FILE: sim/tb_pressure_temp_compensation_top.sv
// Self-checking testbench for the pressure and temperature compensation block.
`timescale 1ns / 1ps

module tb_pressure_temp_compensation_top;
   import ptc_pkg::*;

   // Expected outcome of one sample transfer.
   typedef struct packed {
      logic        pressure_valid;
      logic [31:0] pressure_pa;
      logic [31:0] fine_temperature;
      logic [31:0] temperature_centi;
   } reading_type;

   localparam int unsigned WatchdogLimit = 20000;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // raw_temperature[19:0], raw_pressure[39:20]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;   // temperature_centi, fine_temperature, pressure_pa
   logic        rsp_tuser;   // pressure_valid

   pressure_temp_compensation_top uut (.*);

   // The testbench's own copy of the calibration registers.
   logic [31:0] cal_shadow [CalCount];

   logic [39:0]  pending_samples [$];
   reading_type  expected_readings [$];
   int unsigned  error_count;
   int unsigned  readings_checked;
   int unsigned  invalid_seen;
   int unsigned  idle_cycles;
   int unsigned  burst_left;
   int unsigned  gap_left;
   int unsigned  stall_phase;
   bit           hold_sender;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] sar(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] low32_product(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] full;
      full = {32'd0, a} * {32'd0, b};
      return full[31:0];
   endfunction

   function automatic logic [31:0] widen16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // Integer compensation of one raw sample pair, wrapping at 32 bits throughout.
   function automatic reading_type compensate(input logic [19:0] adc_t,
                                              input logic [19:0] adc_p);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, d, tf, q, qq, div, p, u;
      reading_type r;
      t1 = {16'd0, cal_shadow[CSR_T1_T2][31:16]};
      t2 = widen16(cal_shadow[CSR_T1_T2][15:0]);
      t3 = widen16(cal_shadow[CSR_T3_P1][31:16]);
      p1 = {16'd0, cal_shadow[CSR_T3_P1][15:0]};
      p2 = widen16(cal_shadow[CSR_P2_P3][31:16]);
      p3 = widen16(cal_shadow[CSR_P2_P3][15:0]);
      p4 = widen16(cal_shadow[CSR_P4_P5][31:16]);
      p5 = widen16(cal_shadow[CSR_P4_P5][15:0]);
      p6 = widen16(cal_shadow[CSR_P6_P7][31:16]);
      p7 = widen16(cal_shadow[CSR_P6_P7][15:0]);
      p8 = widen16(cal_shadow[CSR_P8_P9][31:16]);
      p9 = widen16(cal_shadow[CSR_P8_P9][15:0]);

      a = sar(low32_product(({12'd0, adc_t} >> 3) - (t1 << 1), t2), 11);
      d = ({12'd0, adc_t} >> 4) - t1;
      b = sar(low32_product(sar(low32_product(d, d), 12), t3), 14);
      tf = a + b;
      r.fine_temperature = tf;
      r.temperature_centi = sar(low32_product(tf, 32'd5) + 32'd128, 8);

      a = sar(tf, 1) - 32'd64000;
      q = sar(a, 2);
      qq = low32_product(q, q);
      b = low32_product(sar(qq, 11), p6);
      b = b + (low32_product(a, p5) << 1);
      b = sar(b, 2) + (p4 << 16);
      a = sar(sar(low32_product(p3, sar(qq, 13)), 3) + sar(low32_product(p2, a), 1), 18);
      div = sar(low32_product(32'd32768 + a, p1), 15);

      if (div == 32'd0) begin
         r.pressure_pa = 32'd0;
         r.pressure_valid = 1'b0;
      end else begin
         p = low32_product((32'd1048576 - {12'd0, adc_p}) - sar(b, 12), 32'd3125);
         if (p < 32'h8000_0000) begin
            p = (p << 1) / div;
         end else begin
            p = (p / div) << 1;
         end
         u = low32_product(p >> 3, p >> 3) >> 13;
         a = sar(low32_product(p9, u), 12);
         b = sar(low32_product(p >> 2, p8), 13);
         r.pressure_pa = p + sar(a + b + p7, 4);
         r.pressure_valid = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch on %s: got %h, expected %h", what, got, want);
   endtask

   // One write on the calibration channel, waiting for its handshake, then drops csr_valid.
   task automatic write_cal(input csr_idx_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cal_shadow[idx] = value;
      @(posedge clock);
   endtask

   // Waits until every queued sample has gone and every result has come back, then lets the
   // pipeline settle so that the calibration can change safely.
   task automatic drain;
      while (pending_samples.size() != 0 || req_tvalid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // A typical sensor calibration set, roughly as shipped from the factory.
   task automatic load_typical;
      write_cal(CSR_T1_T2, {16'd27504, 16'd26435});
      write_cal(CSR_T3_P1, {16'hFC18, 16'd36477});
      write_cal(CSR_P2_P3, {16'hD5D0, 16'd3024});
      write_cal(CSR_P4_P5, {16'd2855, 16'd140});
      write_cal(CSR_P6_P7, {16'hFFF9, 16'd15500});
      write_cal(CSR_P8_P9, {16'hD1F8, 16'd6000});
   endtask

   task automatic push_sample(input logic [19:0] t, input logic [19:0] p);
      pending_samples.push_back({p, t});
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(compensate(req_tdata[19:0], req_tdata[39:20]));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0 && !hold_sender) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_samples.pop_front();
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls in a repeating pattern, with a quiet stretch in every period.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 300;
         if (stall_phase < 100) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ((stall_phase * 7) % 11) < 4;
         end
      end
   end

   // Monitor: each result transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            error_count++;
            $display("result transfer arrived with nothing expected");
         end else begin
            want = expected_readings.pop_front();
            readings_checked++;
            if (!want.pressure_valid) invalid_seen++;
            if (rsp_tdata[31:0] !== want.temperature_centi)
               report_mismatch("temperature_centi", rsp_tdata[31:0], want.temperature_centi);
            if (rsp_tdata[63:32] !== want.fine_temperature)
               report_mismatch("fine_temperature", rsp_tdata[63:32], want.fine_temperature);
            if (rsp_tdata[95:64] !== want.pressure_pa)
               report_mismatch("pressure_pa", rsp_tdata[95:64], want.pressure_pa);
            if (rsp_tuser !== want.pressure_valid)
               report_mismatch("pressure_valid", {31'd0, rsp_tuser},
                               {31'd0, want.pressure_valid});
         end
      end
   end

   // Watchdog: ends the run if no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_tdata = '0;
      hold_sender = 1'b0;
      error_count = 0;
      readings_checked = 0;
      invalid_seen = 0;
      idle_cycles = 0;
      for (int i = 0; i < CalCount; i++) cal_shadow[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With all calibration at zero the divisor is zero, so pressure is flagged invalid.
      push_sample(20'd0, 20'd0);
      push_sample(20'hFFFFF, 20'hFFFFF);
      drain();

      // Typical calibration with the field extremes and ordinary readings.
      load_typical();
      push_sample(20'd519888, 20'd415148);
      push_sample(20'd0, 20'd0);
      push_sample(20'hFFFFF, 20'hFFFFF);
      push_sample(20'd0, 20'hFFFFF);
      push_sample(20'hFFFFF, 20'd0);
      push_sample(20'h55555, 20'hAAAAA);
      push_sample(20'hAAAAA, 20'h55555);
      drain();

      // Zero P1 forces a zero divisor while temperatures still compute.
      write_cal(CSR_T3_P1, {16'hFC18, 16'd0});
      push_sample(20'd519888, 20'd415148);
      push_sample(20'hFFFFF, 20'd1);
      drain();

      // Extreme coefficients, every word at its largest or most negative value.
      write_cal(CSR_T1_T2, 32'hFFFF_8000);
      write_cal(CSR_T3_P1, 32'h7FFF_FFFF);
      write_cal(CSR_P2_P3, 32'h8000_7FFF);
      write_cal(CSR_P4_P5, 32'h7FFF_8000);
      write_cal(CSR_P6_P7, 32'h8000_7FFF);
      write_cal(CSR_P8_P9, 32'h7FFF_8000);
      push_sample(20'd0, 20'd0);
      push_sample(20'hFFFFF, 20'hFFFFF);
      push_sample(20'h80000, 20'h80000);
      drain();
      write_cal(CSR_T1_T2, 32'hFFFF_FFFF);
      write_cal(CSR_P8_P9, 32'hFFFF_FFFF);
      push_sample(20'd1, 20'hFFFFE);
      push_sample(20'hFFFFF, 20'd0);
      drain();

      // Random phases: mostly near-typical calibration, some fully random.
      for (int phase = 0; phase < 10; phase++) begin
         if (phase % 3 == 0) begin
            for (int r = 0; r < CalCount; r++) write_cal(csr_idx_type'(r), $urandom());
         end else begin
            load_typical();
            write_cal(CSR_T1_T2, {16'($urandom_range(20000, 32000)), 16'($urandom())});
            if (phase == 4) write_cal(CSR_T3_P1, {16'($urandom()), 16'd0});
         end
         for (int n = 0; n < 68; n++) begin
            if ($urandom_range(0, 3) == 0)
               push_sample(20'($urandom()), 20'($urandom()));
            else
               push_sample(20'($urandom_range(400000, 600000)),
                           20'($urandom_range(200000, 500000)));
         end
         // The sender holds off mid-phase until every result is back.
         if (phase == 5) begin
            while (pending_samples.size() > 34) @(posedge clock);
            hold_sender = 1'b1;
            while (req_tvalid || expected_readings.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain();
      end

      $display("covered %0d readings, %0d with a zero pressure divisor,",
               readings_checked, invalid_seen);
      $display("over zero, typical, extreme and random calibration sets");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
